/* design/pad_pkg.sv */
// ----------------------------------------------------------------------------
// pad_pkg
// Shared types and constants for the pot axis dead-band normalizer.
// ----------------------------------------------------------------------------
package pad_pkg;

  localparam int unsigned SMP_W   = 12;  // raw conversion value
  localparam int unsigned POS_W   = 16;  // Q1.15 position
  localparam int unsigned MV_W    = 13;  // millivolts
  localparam int unsigned CNT_W   = 16;  // calibration counter / length
  localparam int unsigned FRAC_W  = 15;  // fraction bits of the position
  localparam int unsigned CIDX_W  = 3;   // register index
  localparam int unsigned CDATA_W = 16;  // register write data

  localparam logic [CNT_W-1:0] RUN_MIN_RST   = 16'hFFFF;
  localparam logic [CNT_W-1:0] CALIB_LEN_RST = 16'd10000;

  // register indexes on the configuration port
  typedef enum logic [CIDX_W-1:0] {
    REG_CONV_MIN  = 3'd0,
    REG_CONV_MAX  = 3'd1,
    REG_REF_MV    = 3'd2,
    REG_BAND_LOW  = 3'd3,
    REG_BAND_HIGH = 3'd4,
    REG_CALIB_LEN = 3'd5
  } pad_reg_e;

  // input beat
  typedef struct packed {
    logic             kind;
    logic [SMP_W-1:0] sample;
  } pad_in_t;

  // result beat
  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic [MV_W-1:0]         voltage_mv;
    logic                    band_latched;
    logic                    div_error;
  } pad_out_t;

  // learned band status from the calibration tracker
  typedef struct packed {
    logic             use_learned;
    logic [SMP_W-1:0] low;
    logic [SMP_W-1:0] high;
  } pad_band_t;

endpackage

/* design/pad_divser.sv */
// ----------------------------------------------------------------------------
// pad_divser
// Bit-serial restoring divider, one quotient bit per cycle.
// The start remainder must be below the divisor; numerator low bits shift in.
// ----------------------------------------------------------------------------
module pad_divser #(
  parameter int unsigned DW = 12,
  parameter int unsigned QW = 15
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] num_i,
  input  logic [DW-1:0] div_i,
  output logic          busy_o,
  output logic [QW-1:0] quot_o
);

  localparam int unsigned CW = $clog2(QW + 1);

  logic [DW-1:0] rem_q, rem_d;
  logic [QW-1:0] sh_q, sh_d;
  logic [DW-1:0] div_q;
  logic [CW-1:0] cnt_q;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // one restoring step: shift in the next numerator bit, try a subtract
  always_comb begin
    trial = {rem_q, sh_q[QW-1]};
    diff  = trial - {1'b0, div_q};
    ge    = (trial >= {1'b0, div_q});
    rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
    sh_d  = {sh_q[QW-2:0], ge};
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i && cnt_q == '0) begin
      cnt_q <= CW'(QW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    if (start_i && cnt_q == '0) begin
      rem_q <= rem_i;
      sh_q  <= num_i;
      div_q <= div_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      sh_q  <= sh_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = sh_q;

  // a start while free always launches a run
  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("divider did not start");

  // the run ends after the last step
  a_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CW'(1)) |=> !busy_o)
    else $error("divider ran past its last step");

  // a run only begins on a start request
  a_rise_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("divider started on its own");

endmodule

/* design/pad_calib.sv */
// ----------------------------------------------------------------------------
// pad_calib
// Calibration tracker: running min and max of calibration samples, and the
// learned dead band latched once the sample count reaches the set length.
// ----------------------------------------------------------------------------
module pad_calib
  import pad_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             strobe_i,
  input  logic [SMP_W-1:0] sample_i,
  input  logic [CNT_W-1:0] calib_len_i,
  input  logic             clear_i,
  output pad_band_t        band_o,
  output logic             latch_o
);

  logic [SMP_W-1:0] run_max_q;
  logic [CNT_W-1:0] run_min_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] cnt_inc;
  logic [SMP_W-1:0] max_upd;
  logic [CNT_W-1:0] min_upd;
  logic [SMP_W-1:0] low_q, high_q;
  logic             use_q;

  // running extremes including this sample
  always_comb begin
    cnt_inc = cnt_q + CNT_W'(1);
    max_upd = (sample_i > run_max_q) ? sample_i : run_max_q;
    min_upd = ({4'd0, sample_i} < run_min_q) ? {4'd0, sample_i} : run_min_q;
    latch_o = strobe_i && (cnt_inc >= calib_len_i);
  end

  // tracker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_max_q <= '0;
      run_min_q <= RUN_MIN_RST;
      cnt_q     <= '0;
      use_q     <= 1'b0;
    end else if (latch_o) begin
      run_max_q <= '0;
      run_min_q <= RUN_MIN_RST;
      cnt_q     <= '0;
      use_q     <= 1'b1;
    end else begin
      if (strobe_i) begin
        run_max_q <= max_upd;
        run_min_q <= min_upd;
        cnt_q     <= cnt_inc;
      end
      if (clear_i) begin
        use_q <= 1'b0;
      end
    end
  end

  // learned band, no reset: only read once use_q is set
  always_ff @(posedge clk_i) begin
    if (latch_o) begin
      low_q  <= min_upd[SMP_W-1:0];
      high_q <= max_upd;
    end
  end

  assign band_o = '{use_learned: use_q, low: low_q, high: high_q};

  // an empty count means no sample has been folded in
  a_empty_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (run_max_q == '0 && run_min_q == RUN_MIN_RST))
    else $error("running extremes not reset with counter");

  // a latch switches to the learned band
  a_latch_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latch_o |=> use_q)
    else $error("latch did not select learned band");

  // a band write goes back to the configured band
  a_clear_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clear_i && !latch_o) |=> !use_q)
    else $error("band write did not drop learned band");

endmodule

/* design/pot_axis_deadband_normalizer.sv */
// ----------------------------------------------------------------------------
// pot_axis_deadband_normalizer
// Potentiometer axis normalizer with center dead band and calibration.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid_i / in_stall_o, beat carries kind and sample.
//   out channel : out_valid_o / out_stall_i, one result beat per input beat.
//   cfg channel : cfg_valid_i / cfg_ready_o with register index and data;
//                 write registers only while the block is idle.
// Sequencing:
//   a measure beat runs through setup, multiply, start and divide states; both
//   quotients come from bit-serial dividers (15 steps for position, 13 for
//   voltage) behind the setup state and a registered 12x13 product.
//   a calibration beat goes from accept straight to the finish state.
//   one beat is in work at a time; the next beat is taken the cycle after
//   the result is written to the output register.
// Stall:
//   a stalled result holds in the output register while the next beat is
//   taken and worked; that beat waits to finish until the register frees.
// Reset:
//   registers go to their documented defaults, calibration restarts and the
//   configured band is in force.
// ----------------------------------------------------------------------------
module pot_axis_deadband_normalizer
  import pad_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pad_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pad_out_t           out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CIDX_W-1:0]  cfg_index_i,
  input  logic [CDATA_W-1:0] cfg_data_i
);

  localparam int unsigned PROD_W = SMP_W + MV_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_MUL,
    S_START,
    S_DIV,
    S_FINISH
  } state_e;

  typedef enum logic [2:0] {
    POS_ZERO,
    POS_SAT_HI,
    POS_SAT_LO,
    POS_QUOT_UP,
    POS_QUOT_DN
  } pos_mode_e;

  // configuration registers
  logic [SMP_W-1:0] conv_min_q, conv_max_q;
  logic [MV_W-1:0]  ref_mv_q;
  logic [SMP_W-1:0] band_low_q, band_high_q;
  logic [CNT_W-1:0] calib_len_q;

  state_e           state_q;
  logic             kind_q;
  logic [SMP_W-1:0] smp_q;
  logic             latched_q;
  logic             err_q;
  pos_mode_e        pos_mode_q;
  logic [SMP_W-1:0] pr_rem_q, pr_div_q;
  logic [SMP_W-1:0] a_q;
  logic [SMP_W-1:0] span_q;
  logic             volt_ok_q;
  logic [PROD_W-1:0] prod_q;
  pad_out_t         out_q;
  logic             out_valid_q;

  logic             in_accept;
  logic             cfg_we;
  logic             band_clear;
  logic [SMP_W-1:0] smp_masked;
  pad_band_t        band;
  logic             calib_latch;
  logic             div_start;
  logic             pos_busy, mv_busy;
  logic [FRAC_W-1:0] pos_quot;
  logic [MV_W-1:0]  mv_quot;

  // setup-cycle decisions
  logic [SMP_W-1:0] lo, hi;
  logic [SMP_W-1:0] n_up, d_up, n_dn, d_dn;
  logic [SMP_W-1:0] clamped;
  pos_mode_e        mode_d;
  logic             err_d;
  logic [SMP_W-1:0] rem_d, dvs_d;
  pad_out_t         res_d;
  logic signed [POS_W-1:0] q_pos;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign cfg_we     = cfg_valid_i && cfg_ready_o;
  assign band_clear = cfg_we && (cfg_index_i == REG_BAND_LOW ||
                                 cfg_index_i == REG_BAND_HIGH);
  assign div_start  = (state_q == S_START);

  // keep only the converter's resolution
  always_comb begin
    for (int i = 0; i < SMP_W; i++) begin
      smp_masked[i] = in_data_i.sample[i] && (i < SAMPLE_BITS);
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_min_q  <= '0;
      conv_max_q  <= 12'd4095;
      ref_mv_q    <= 13'd3300;
      band_low_q  <= 12'd2048;
      band_high_q <= 12'd2048;
      calib_len_q <= CALIB_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_CONV_MIN:  conv_min_q  <= cfg_data_i[SMP_W-1:0];
        REG_CONV_MAX:  conv_max_q  <= cfg_data_i[SMP_W-1:0];
        REG_REF_MV:    ref_mv_q    <= cfg_data_i[MV_W-1:0];
        REG_BAND_LOW:  band_low_q  <= cfg_data_i[SMP_W-1:0];
        REG_BAND_HIGH: band_high_q <= cfg_data_i[SMP_W-1:0];
        REG_CALIB_LEN: calib_len_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  pad_calib u_calib (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .strobe_i    (in_accept && in_data_i.kind),
    .sample_i    (smp_masked),
    .calib_len_i (calib_len_q),
    .clear_i     (band_clear),
    .band_o      (band),
    .latch_o     (calib_latch)
  );

  // band edges and position case selection
  always_comb begin
    lo      = band.use_learned ? band.low  : band_low_q;
    hi      = band.use_learned ? band.high : band_high_q;
    n_up    = smp_q - hi;
    d_up    = conv_max_q - hi;
    n_dn    = lo - smp_q;
    d_dn    = lo - conv_min_q;
    mode_d  = POS_ZERO;
    err_d   = 1'b0;
    rem_d   = n_up;
    dvs_d   = d_up;
    if (smp_q >= hi) begin
      if (conv_max_q <= hi) begin
        err_d  = (conv_max_q == hi);
        mode_d = (smp_q == hi) ? POS_ZERO : POS_SAT_HI;
      end else if (n_up >= d_up) begin
        mode_d = POS_SAT_HI;
      end else begin
        mode_d = POS_QUOT_UP;
      end
    end else if (smp_q < lo) begin
      rem_d = n_dn;
      dvs_d = d_dn;
      if (lo <= conv_min_q) begin
        err_d  = (lo == conv_min_q);
        mode_d = POS_SAT_LO;
      end else if (n_dn >= d_dn) begin
        mode_d = POS_SAT_LO;
      end else begin
        mode_d = POS_QUOT_DN;
      end
    end
    if (smp_q < conv_min_q) begin
      clamped = conv_min_q;
    end else if (smp_q > conv_max_q) begin
      clamped = conv_max_q;
    end else begin
      clamped = smp_q;
    end
  end

  pad_divser #(.DW(SMP_W), .QW(FRAC_W)) u_pos_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (pr_rem_q),
    .num_i   ('0),
    .div_i   (pr_div_q),
    .busy_o  (pos_busy),
    .quot_o  (pos_quot)
  );

  pad_divser #(.DW(SMP_W), .QW(MV_W)) u_mv_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (prod_q[PROD_W-1:MV_W]),
    .num_i   (prod_q[MV_W-1:0]),
    .div_i   (span_q),
    .busy_o  (mv_busy),
    .quot_o  (mv_quot)
  );

  // result beat assembly
  always_comb begin
    q_pos = $signed({1'b0, pos_quot});
    res_d = '0;
    res_d.band_latched = latched_q;
    if (!kind_q) begin
      res_d.div_error  = err_q;
      res_d.voltage_mv = volt_ok_q ? mv_quot : '0;
      case (pos_mode_q)
        POS_ZERO:    res_d.position = '0;
        POS_SAT_HI:  res_d.position = 16'sh7FFF;
        POS_SAT_LO:  res_d.position = 16'sh8000;
        POS_QUOT_UP: res_d.position = q_pos;
        POS_QUOT_DN: res_d.position = -q_pos;
        default:     res_d.position = '0;
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_FINISH) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            state_q <= in_data_i.kind ? S_FINISH : S_SETUP;
          end
        end
        S_SETUP:  state_q <= S_MUL;
        S_MUL:    state_q <= S_START;
        S_START:  state_q <= S_DIV;
        S_DIV: begin
          if (!pos_busy && !mv_busy) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_q       <= res_d;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // item payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q    <= in_data_i.kind;
      smp_q     <= smp_masked;
      latched_q <= calib_latch;
    end
    if (state_q == S_SETUP) begin
      pos_mode_q <= mode_d;
      pr_rem_q   <= rem_d;
      pr_div_q   <= dvs_d;
      a_q        <= clamped - conv_min_q;
      span_q     <= conv_max_q - conv_min_q;
      volt_ok_q  <= (conv_max_q > conv_min_q);
      err_q      <= err_d || (conv_max_q == conv_min_q);
    end
    if (state_q == S_MUL) begin
      prod_q <= PROD_W'(a_q) * PROD_W'(ref_mv_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // dividers are never running while a new beat can come in
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!pos_busy && !mv_busy))
    else $error("divider busy in idle");

  // a result that latched the band carries no position and no divide error
  a_calib_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.band_latched) |->
      (out_data_o.position == '0 && out_data_o.div_error == 1'b0))
    else $error("calibration result carries measurement data");

  // an accepted beat leaves idle at once
  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_SETUP || state_q == S_FINISH))
    else $error("accepted beat did not start");

  // finishing only loads a free or draining output register
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && out_valid_q && out_stall_i) |=> $stable(out_q))
    else $error("result overwritten while stalled");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pot axis dead-band normalizer. A directed table
// covers range extremes, zero denominators, inverted ranges and band latching.
// Random phases then reprogram the registers and mix measure and calibration
// beats. Each result beat is compared with its table value or a local model.
// ----------------------------------------------------------------------------
module tb_top;
  import pad_pkg::*;

  localparam int CYCLE_LIMIT     = 500000;
  localparam int NUM_PHASES      = 6;
  localparam int BEATS_PER_PHASE = 275;
  localparam int DRAIN_CYCLES    = 40;
  localparam int POS_TOP         = 32767;
  localparam int Q_ONE           = 32768;
  localparam int SMP_TOP         = 4095;

  localparam logic KIND_MEASURE = 1'b0;
  localparam logic KIND_CALIB   = 1'b1;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_op_e;

  typedef struct {
    row_op_e     op;
    pad_reg_e    idx;
    int unsigned val;
    pad_in_t     beat;
    bit          typed;
    pad_out_t    res;
  } row_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid    = 1'b0;
  pad_in_t            in_data     = '0;
  logic               in_stall;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  pad_out_t           out_data;
  logic               cfg_valid   = 1'b0;
  logic               cfg_ready;
  logic [CIDX_W-1:0]  cfg_index   = '0;
  logic [CDATA_W-1:0] cfg_data    = '0;

  // model copy of registers and calibration state
  int conv_lo, conv_hi, ref_mv, band_lo, band_hi, calib_len;
  int cal_max, cal_min, cal_count, lrn_lo, lrn_hi;
  bit lrn_on;

  pad_out_t axis_due_q[$];
  row_t     stim_rows[$];
  int       mismatch_cnt = 0;
  int       cycle_cnt    = 0;
  int       stall_left   = 0;
  bit       idle_on      = 1'b0;

  pot_axis_deadband_normalizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side back-pressure in random bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 6) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each accepted result beat with the oldest prediction
  always @(posedge clk_i) begin
    pad_out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (axis_due_q.size() == 0) begin
        $display("%0t unexpected result beat: expected none, got %h", $time, out_data);
        mismatch_cnt++;
      end else begin
        want = axis_due_q.pop_front();
        if (out_data.position !== want.position) begin
          $display("%0t position mismatch: expected %0d, got %0d",
                   $time, want.position, out_data.position);
          mismatch_cnt++;
        end
        if (out_data.voltage_mv !== want.voltage_mv) begin
          $display("%0t voltage_mv mismatch: expected %0d, got %0d",
                   $time, want.voltage_mv, out_data.voltage_mv);
          mismatch_cnt++;
        end
        if (out_data.band_latched !== want.band_latched) begin
          $display("%0t band_latched mismatch: expected %0b, got %0b",
                   $time, want.band_latched, out_data.band_latched);
          mismatch_cnt++;
        end
        if (out_data.div_error !== want.div_error) begin
          $display("%0t div_error mismatch: expected %0b, got %0b",
                   $time, want.div_error, out_data.div_error);
          mismatch_cnt++;
        end
      end
    end
  end

  // model state after reset
  task automatic reset_model();
    conv_lo   = 0;
    conv_hi   = SMP_TOP;
    ref_mv    = 3300;
    band_lo   = 2048;
    band_hi   = 2048;
    calib_len = int'(CALIB_LEN_RST);
    cal_max   = 0;
    cal_min   = int'(RUN_MIN_RST);
    cal_count = 0;
    lrn_lo    = 0;
    lrn_hi    = 0;
    lrn_on    = 1'b0;
  endtask

  task automatic apply_reg(input pad_reg_e idx, input int unsigned val);
    case (idx)
      REG_CONV_MIN:  conv_lo = val & 'hFFF;
      REG_CONV_MAX:  conv_hi = val & 'hFFF;
      REG_REF_MV:    ref_mv = val & 'h1FFF;
      REG_BAND_LOW:  begin
        band_lo = val & 'hFFF;
        lrn_on  = 1'b0;
      end
      REG_BAND_HIGH: begin
        band_hi = val & 'hFFF;
        lrn_on  = 1'b0;
      end
      REG_CALIB_LEN: calib_len = val & 'hFFFF;
      default: ;
    endcase
  endtask

  // dead-band position, clamped voltage and calibration tracking for one beat
  task automatic normalize_sample(input pad_in_t b, output pad_out_t r);
    int     v, lo, hi, d, n, c;
    longint q;
    logic   err;
    r   = '0;
    err = 1'b0;
    v   = int'(b.sample);
    if (b.kind == KIND_CALIB) begin
      if (v > cal_max) cal_max = v;
      if (v < cal_min) cal_min = v;
      cal_count = (cal_count + 1) & 'hFFFF;
      if (cal_count >= calib_len) begin
        lrn_lo         = cal_min & 'hFFF;
        lrn_hi         = cal_max & 'hFFF;
        lrn_on         = 1'b1;
        r.band_latched = 1'b1;
        cal_max        = 0;
        cal_min        = int'(RUN_MIN_RST);
        cal_count      = 0;
      end
    end else begin
      lo = lrn_on ? lrn_lo : band_lo;
      hi = lrn_on ? lrn_hi : band_hi;
      // upper side, edge sample included
      if (v >= hi) begin
        d = conv_hi - hi;
        n = v - hi;
        if (d <= 0) begin
          if (d == 0) err = 1'b1;
          r.position = POS_W'((n == 0) ? 0 : POS_TOP);
        end else begin
          q = (longint'(n) * Q_ONE) / d;
          r.position = POS_W'((q > POS_TOP) ? POS_TOP : q);
        end
      end else if (v < lo) begin
        d = lo - conv_lo;
        n = lo - v;
        if (d <= 0) begin
          if (d == 0) err = 1'b1;
          r.position = POS_W'(-Q_ONE);
        end else begin
          q = (longint'(n) * Q_ONE) / d;
          if (q > Q_ONE) q = Q_ONE;
          r.position = POS_W'(-q);
        end
      end
      // voltage over the clamped span
      if (conv_hi <= conv_lo) begin
        if (conv_hi == conv_lo) err = 1'b1;
      end else begin
        c = v;
        if (c < conv_lo) c = conv_lo;
        if (c > conv_hi) c = conv_hi;
        r.voltage_mv = MV_W'((longint'(c - conv_lo) * ref_mv) / (conv_hi - conv_lo));
      end
      r.div_error = err;
    end
  endtask

  // one register write; valid stays up for a following write
  task automatic set_reg(input pad_reg_e idx, input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CDATA_W-1:0];
    do @(posedge clk_i); while (!(cfg_valid && cfg_ready));
    apply_reg(idx, val);
  endtask

  // one input beat with an optional idle burst in front
  task automatic send_beat(input pad_in_t b, input bit typed, input pad_out_t res);
    pad_out_t pred;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk_i); while (!(in_valid && !in_stall));
    normalize_sample(b, pred);
    axis_due_q.push_back(typed ? res : pred);
  endtask

  task automatic wait_drained();
    while (axis_due_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_cfg(input pad_reg_e idx, input int unsigned val);
    row_t row;
    row = '{op: ROW_CFG, idx: idx, val: val, beat: '0, typed: 1'b0, res: '0};
    stim_rows.push_back(row);
  endtask

  task automatic add_beat(input logic kind, input int smp, input bit typed = 1'b0,
                          input int pos = 0, input int mv = 0,
                          input logic latched = 1'b0, input logic err = 1'b0);
    row_t row;
    row = '{op: ROW_BEAT, idx: REG_CONV_MIN, val: 0, beat: '0, typed: 1'b0, res: '0};
    row.beat.kind        = kind;
    row.beat.sample      = SMP_W'(smp);
    row.typed            = typed;
    row.res.position     = POS_W'(pos);
    row.res.voltage_mv   = MV_W'(mv);
    row.res.band_latched = latched;
    row.res.div_error    = err;
    stim_rows.push_back(row);
  endtask

  task automatic build_directed();
    // reset settings: full span, band at mid scale
    add_beat(KIND_MEASURE, 0, 1, -Q_ONE, 0, 0, 0);
    add_beat(KIND_MEASURE, SMP_TOP, 1, POS_TOP, 3300, 0, 0);
    add_beat(KIND_MEASURE, 2048);
    add_beat(KIND_MEASURE, 2047);
    add_beat(KIND_CALIB, 0, 1, 0, 0, 0, 0);
    add_beat(KIND_CALIB, SMP_TOP, 1, 0, 0, 0, 0);
    // shorter run latches the band 0..4095
    add_cfg(REG_CALIB_LEN, 3);
    add_beat(KIND_CALIB, 100, 1, 0, 0, 1, 0);
    add_beat(KIND_MEASURE, SMP_TOP, 1, 0, 3300, 0, 1);
    add_beat(KIND_MEASURE, 0, 1, 0, 0, 0, 0);
    // upper span negative
    add_cfg(REG_BAND_LOW, 1000);
    add_cfg(REG_CONV_MAX, 1000);
    add_beat(KIND_MEASURE, 3000, 1, POS_TOP, 3300, 0, 0);
    add_beat(KIND_MEASURE, 2048, 1, 0, 3300, 0, 0);
    // zero lower span and zero voltage span
    add_cfg(REG_CONV_MIN, 1000);
    add_beat(KIND_MEASURE, 500, 1, -Q_ONE, 0, 0, 1);
    // inverted converter range
    add_cfg(REG_CONV_MIN, 1500);
    add_beat(KIND_MEASURE, 500, 1, -Q_ONE, 0, 0, 0);
    add_beat(KIND_MEASURE, 1500, 1, 0, 0, 0, 0);
    // full reference voltage
    add_cfg(REG_CONV_MIN, 0);
    add_cfg(REG_CONV_MAX, SMP_TOP);
    add_cfg(REG_REF_MV, 5000);
    add_beat(KIND_MEASURE, SMP_TOP, 1, POS_TOP, 5000, 0, 0);
    add_beat(KIND_MEASURE, 1);
    add_cfg(REG_REF_MV, 0);
    add_beat(KIND_MEASURE, 3000);
    // single-sample calibration
    add_cfg(REG_CALIB_LEN, 1);
    add_beat(KIND_CALIB, 2500, 1, 0, 0, 1, 0);
    add_beat(KIND_MEASURE, 2500);
    add_beat(KIND_MEASURE, 2499);
    add_cfg(REG_CALIB_LEN, 'hFFFF);
    add_beat(KIND_CALIB, 7, 1, 0, 0, 0, 0);
    add_cfg(REG_BAND_HIGH, SMP_TOP);
    add_beat(KIND_MEASURE, SMP_TOP);
  endtask

  // new register setting for a random phase, skewed toward sane ranges
  task automatic random_setup(input bit all);
    int lo, hi;
    case ($urandom_range(0, 9))
      0: begin
        lo = $urandom_range(0, SMP_TOP);
        hi = lo;
      end
      1: begin
        hi = $urandom_range(0, 3000);
        lo = hi + $urandom_range(1, 1095);
      end
      2: begin
        lo = 0;
        hi = SMP_TOP;
      end
      default: begin
        lo = $urandom_range(0, 1200);
        hi = $urandom_range(2800, SMP_TOP);
      end
    endcase
    if (all || $urandom_range(0, 3) != 0) set_reg(REG_CONV_MIN, lo);
    if (all || $urandom_range(0, 3) != 0) set_reg(REG_CONV_MAX, hi);
    if (all || $urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 4))
        0:       set_reg(REG_REF_MV, 0);
        1:       set_reg(REG_REF_MV, 5000);
        default: set_reg(REG_REF_MV, $urandom_range(0, 5000));
      endcase
    end
    case ($urandom_range(0, 7))
      0: begin
        lo = $urandom_range(0, SMP_TOP);
        hi = $urandom_range(0, SMP_TOP);
      end
      1: begin
        lo = $urandom_range(0, SMP_TOP);
        hi = lo;
      end
      default: begin
        lo = $urandom_range(1000, 2048);
        hi = $urandom_range(2048, 3100);
      end
    endcase
    if (all || $urandom_range(0, 3) != 0) set_reg(REG_BAND_LOW, lo);
    if (all || $urandom_range(0, 3) != 0) set_reg(REG_BAND_HIGH, hi);
    if (all || $urandom_range(0, 3) != 0)
      set_reg(REG_CALIB_LEN, ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12));
  endtask

  // random beat: measure or calibration, samples biased to edges and extremes
  function automatic pad_in_t random_beat();
    pad_in_t b;
    int      s, e;
    b.kind = ($urandom_range(0, 99) < 30) ? KIND_CALIB : KIND_MEASURE;
    case ($urandom_range(0, 7))
      0: s = 0;
      1: s = SMP_TOP;
      2: begin
        if ($urandom_range(0, 1) != 0) e = lrn_on ? lrn_hi : band_hi;
        else e = lrn_on ? lrn_lo : band_lo;
        s = e + $urandom_range(0, 4) - 2;
      end
      3: begin
        e = ($urandom_range(0, 1) != 0) ? conv_hi : conv_lo;
        s = e + $urandom_range(0, 4) - 2;
      end
      default: s = $urandom_range(0, SMP_TOP);
    endcase
    if (s < 0) s = 0;
    if (s > SMP_TOP) s = SMP_TOP;
    b.sample = SMP_W'(s);
    return b;
  endfunction

  initial begin
    row_t row;
    bit   prev_cfg;
    reset_model();
    build_directed();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    idle_on  = 1'b1;
    prev_cfg = 1'b0;
    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.op == ROW_CFG) begin
        if (!prev_cfg) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        set_reg(row.idx, row.val);
        prev_cfg = 1'b1;
      end else begin
        if (prev_cfg) cfg_valid <= 1'b0;
        send_beat(row.beat, row.typed, row.res);
        prev_cfg = 1'b0;
      end
    end

    // random phases, quiet stretch in the middle and at the end
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      in_valid <= 1'b0;
      wait_drained();
      idle_on = (ph != 2) && (ph != NUM_PHASES - 1);
      random_setup(ph == 0);
      cfg_valid <= 1'b0;
      for (int i = 0; i < BEATS_PER_PHASE; i++) begin
        send_beat(random_beat(), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && axis_due_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* pot_axis_deadband_normalizer.f */
design/pad_pkg.sv
design/pad_divser.sv
design/pad_calib.sv
design/pot_axis_deadband_normalizer.sv
verif/tb_top.sv
